// ===== rtl/core/mcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared constants and types for the memoized Collatz step counter.
// ----------------------------------------------------------------------------
package mcsc_pkg;

  localparam int unsigned ENTRIES    = 16;   // must be a power of two
  localparam int unsigned KEY_BITS   = 20;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned RANK_W     = IDX_W;
  localparam int unsigned LIMIT_W    = IDX_W + 1;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned TOTAL_W    = 32;
  // peak of any walk from a 20-bit start stays below 2^37
  localparam int unsigned WALK_W     = 48;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [LFSR_W-1:0]    LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0]    LFSR_ONE  = 16'h0001;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 8'd1;

  typedef struct packed {
    logic               touch;      // hit: promote matching entry
    logic               insert;     // miss: write new pair
    logic [COUNT_W-1:0] count;
    logic               rand_mode;
    logic [IDX_W-1:0]   rand_slot;
  } cache_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] stored_count;
    logic               full;
  } cache_rsp_t;

endpackage

// ===== rtl/core/memoized_collatz_step_counter.sv =====
// ----------------------------------------------------------------------------
// memoized_collatz_step_counter
// Collatz step counter with a 16-entry fully associative result cache.
// Hit: the key is registered, looked up, and the cached count registered as the
//   result; miss: looked up, walked one step per cycle, then inserted.
// Throughput: one item at a time; ready again once the result is registered,
//   which waits while the output register is still held.
// Reset: cache empty, totals zero, LRU mode, LFSR state 1.
// ----------------------------------------------------------------------------
module memoized_collatz_step_counter import mcsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KEY_BITS-1:0]   start_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COUNT_W-1:0]    step_count_o,
  output logic                  was_hit_o,
  output logic [TOTAL_W-1:0]    hit_total_o,
  output logic [TOTAL_W-1:0]    miss_total_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_INSERT
  } state_e;

  state_e              state_q, state_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                mode_q, mode_d;
  logic [LFSR_W-1:0]   lfsr_q, lfsr_d;
  logic [TOTAL_W-1:0]  hits_q, hits_d;
  logic [TOTAL_W-1:0]  misses_q, misses_d;
  logic                out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]  step_count_q, step_count_d;
  logic                was_hit_q, was_hit_d;
  logic [TOTAL_W-1:0]  hit_total_q, hit_total_d;
  logic [TOTAL_W-1:0]  miss_total_q, miss_total_d;

  logic [LFSR_W-1:0]   lfsr_next;
  logic                out_free;
  logic                walk_start;
  logic                walk_done;
  logic [COUNT_W-1:0]  walk_steps;
  cache_cmd_t          cache_cmd;
  cache_rsp_t          cache_rsp;

  mcsc_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (walk_start),
    .start_value_i (key_q),
    .done_o        (walk_done),
    .steps_o       (walk_steps)
  );

  mcsc_cache u_cache (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .cmd_i  (cache_cmd),
    .rsp_o  (cache_rsp)
  );

  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    mode_d       = mode_q;
    lfsr_d       = lfsr_q;
    hits_d       = hits_q;
    misses_d     = misses_q;
    out_valid_d  = out_valid_q;
    step_count_d = step_count_q;
    was_hit_d    = was_hit_q;
    hit_total_d  = hit_total_q;
    miss_total_d = miss_total_q;
    walk_start   = 1'b0;

    cache_cmd           = '0;
    cache_cmd.count     = walk_steps;
    cache_cmd.rand_mode = mode_q;
    cache_cmd.rand_slot = lfsr_next[IDX_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE: mode_d = cfg_data_i[0];
        REG_SEED: lfsr_d = (cfg_data_i != '0) ? LFSR_W'(cfg_data_i) : LFSR_ONE;
        default:  ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = start_value_i;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (cache_rsp.hit) begin
          if (out_free) begin
            cache_cmd.touch = 1'b1;
            hits_d       = (hits_q == '1) ? hits_q : hits_q + TOTAL_W'(1);
            out_valid_d  = 1'b1;
            step_count_d = cache_rsp.stored_count;
            was_hit_d    = 1'b1;
            hit_total_d  = hits_d;
            miss_total_d = misses_q;
            state_d      = ST_IDLE;
          end
        end else begin
          misses_d   = (misses_q == '1) ? misses_q : misses_q + TOTAL_W'(1);
          walk_start = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          cache_cmd.insert = 1'b1;
          // random victim: LFSR steps only when an eviction happens
          if (cache_rsp.full && mode_q) begin
            lfsr_d = lfsr_next;
          end
          out_valid_d  = 1'b1;
          step_count_d = walk_steps;
          was_hit_d    = 1'b0;
          hit_total_d  = hits_q;
          miss_total_d = misses_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_q        <= '0;
      mode_q       <= 1'b0;
      lfsr_q       <= LFSR_ONE;
      hits_q       <= '0;
      misses_q     <= '0;
      out_valid_q  <= 1'b0;
      step_count_q <= '0;
      was_hit_q    <= 1'b0;
      hit_total_q  <= '0;
      miss_total_q <= '0;
    end else begin
      state_q      <= state_d;
      key_q        <= key_d;
      mode_q       <= mode_d;
      lfsr_q       <= lfsr_d;
      hits_q       <= hits_d;
      misses_q     <= misses_d;
      out_valid_q  <= out_valid_d;
      step_count_q <= step_count_d;
      was_hit_q    <= was_hit_d;
      hit_total_q  <= hit_total_d;
      miss_total_q <= miss_total_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign step_count_o = step_count_q;
  assign was_hit_o    = was_hit_q;
  assign hit_total_o  = hit_total_q;
  assign miss_total_o = miss_total_q;

endmodule

// ===== rtl/core/mcsc_walk.sv =====
// ----------------------------------------------------------------------------
// mcsc_walk
// Iterative Collatz walker: one halve or 3n+1 step per cycle, step counter
// saturates at COUNT_MAX.
// ----------------------------------------------------------------------------
module mcsc_walk import mcsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KEY_BITS-1:0] start_value_i,
  output logic                done_o,
  output logic [COUNT_W-1:0]  steps_o
);

  logic [WALK_W-1:0]  value_q;
  logic [COUNT_W-1:0] steps_q;
  logic               run_q;
  logic               finished;
  logic [WALK_W-1:0]  value_next;

  assign finished   = (value_q == WALK_W'(1)) || (steps_q == COUNT_MAX);
  assign value_next = value_q[0] ? ((value_q << 1) + value_q + WALK_W'(1))
                                 : (value_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      steps_q <= '0;
      run_q   <= 1'b0;
    end else if (start_i) begin
      value_q <= WALK_W'(start_value_i);
      steps_q <= '0;
      run_q   <= 1'b1;
    end else if (run_q) begin
      if (finished) begin
        run_q <= 1'b0;
      end else begin
        value_q <= value_next;
        steps_q <= steps_q + COUNT_W'(1);
      end
    end
  end

  assign done_o  = run_q && finished;
  assign steps_o = steps_q;

endmodule

// ===== rtl/core/mcsc_cache.sv =====
// ----------------------------------------------------------------------------
// mcsc_cache
// Fully associative table of (key, count) pairs with recency ranks,
// free-slot search and LRU / random victim choice.
// ----------------------------------------------------------------------------
module mcsc_cache import mcsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_BITS-1:0] key_i,
  input  cache_cmd_t          cmd_i,
  output cache_rsp_t          rsp_o
);

  logic [KEY_BITS-1:0] key_q   [ENTRIES];
  logic [COUNT_W-1:0]  count_q [ENTRIES];
  logic [RANK_W-1:0]   rank_q  [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;

  logic [ENTRIES-1:0]  hit_vec;
  logic [IDX_W-1:0]    hit_slot;
  logic [IDX_W-1:0]    free_slot;
  logic [IDX_W-1:0]    lru_slot;
  logic [IDX_W-1:0]    slot;
  logic [LIMIT_W-1:0]  used;
  logic [LIMIT_W-1:0]  limit;
  logic                full;

  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    lru_slot  = '0;
    used      = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
      if (hit_vec[i]) begin
        hit_slot = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_slot = IDX_W'(i);
      end
      // when full the ranks form a permutation; the oldest has the top rank
      if (rank_q[i] == RANK_W'(ENTRIES - 1)) begin
        lru_slot = IDX_W'(i);
      end
      used = used + LIMIT_W'(valid_q[i]);
    end
    full = &valid_q;

    if (cmd_i.touch) begin
      slot  = hit_slot;
      limit = LIMIT_W'(rank_q[hit_slot]);
    end else if (!full) begin
      slot  = free_slot;
      limit = used;
    end else begin
      slot  = cmd_i.rand_mode ? cmd_i.rand_slot : lru_slot;
      limit = LIMIT_W'(rank_q[slot]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.touch || cmd_i.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (LIMIT_W'(rank_q[i]) < limit)) begin
          rank_q[i] <= rank_q[i] + RANK_W'(1);
        end
      end
      if (cmd_i.insert) begin
        valid_q[slot] <= 1'b1;
      end
    end
  end

  // pair storage, no reset: only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      key_q[slot]   <= key_i;
      count_q[slot] <= cmd_i.count;
    end
  end

  assign rsp_o.hit          = |hit_vec;
  assign rsp_o.stored_count = count_q[hit_slot];
  assign rsp_o.full         = full;

endmodule

// ===== verif/memoized_collatz_step_counter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memoized_collatz_step_counter_tb
// Drives start values through the step counter and checks every answer
// (step count, hit flag, hit and miss totals) against a cycle-free model of
// the result cache that tracks LRU ranks and the random-victim LFSR.
// ----------------------------------------------------------------------------
module memoized_collatz_step_counter_tb import mcsc_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RECENT_DEPTH   = 20;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_HI = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] MODE_LRU      = 16'd0;
  localparam logic [CFG_DATA_W-1:0] MODE_RANDOM   = 16'd1;

  typedef struct packed {
    logic [COUNT_W-1:0] steps;
    logic               hit;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
  } answer_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [KEY_BITS-1:0]   start_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [COUNT_W-1:0]    step_count_o;
  logic                  was_hit_o;
  logic [TOTAL_W-1:0]    hit_total_o;
  logic [TOTAL_W-1:0]    miss_total_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // cache model
  logic [KEY_BITS-1:0] memo_key   [ENTRIES];
  logic [COUNT_W-1:0]  memo_steps [ENTRIES];
  logic                memo_valid [ENTRIES];
  logic [RANK_W-1:0]   memo_rank  [ENTRIES];
  logic [TOTAL_W-1:0]  hit_tally;
  logic [TOTAL_W-1:0]  miss_tally;
  logic [LFSR_W-1:0]   victim_lfsr;
  logic                evict_random;

  answer_t             expected_answers[$];
  logic [KEY_BITS-1:0] recent_starts[$];
  int                  mismatch_count;
  int                  quiet_cycles;
  int                  stall_left;
  bit                  idling;

  memoized_collatz_step_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_value_i (start_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .step_count_o  (step_count_o),
    .was_hit_o     (was_hit_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [COUNT_W-1:0] collatz_steps(input logic [63:0] n);
    int steps;
    steps = 0;
    while (n != 64'd1 && steps < int'(COUNT_MAX)) begin
      if (n[0]) n = 3 * n + 1;
      else n = n >> 1;
      steps++;
    end
    return steps[COUNT_W-1:0];
  endfunction

  function automatic void make_most_recent(input int slot, input int limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && memo_valid[i] && int'(memo_rank[i]) < limit) memo_rank[i]++;
    end
    memo_rank[slot] = '0;
  endfunction

  function automatic answer_t collatz_lookup(input logic [KEY_BITS-1:0] key);
    answer_t ans;
    int      slot;
    int      used;
    int      limit;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && memo_valid[i] && memo_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      if (hit_tally != '1) hit_tally++;
      make_most_recent(slot, int'(memo_rank[slot]));
      ans.steps = memo_steps[slot];
      ans.hit   = 1'b1;
    end else begin
      if (miss_tally != '1) miss_tally++;
      ans.steps = collatz_steps({{(64-KEY_BITS){1'b0}}, key});
      ans.hit   = 1'b0;
      used = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (memo_valid[i]) used++;
        else if (slot < 0) slot = i;
      end
      if (slot >= 0) begin
        limit = used;
      end else begin
        if (evict_random) begin
          victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS) : (victim_lfsr >> 1);
          slot = int'(victim_lfsr[IDX_W-1:0]);
        end else begin
          slot = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (memo_rank[i] > memo_rank[slot]) slot = i;
          end
        end
        limit = int'(memo_rank[slot]);
      end
      make_most_recent(slot, limit);
      memo_key[slot]   = key;
      memo_steps[slot] = ans.steps;
      memo_valid[slot] = 1'b1;
    end
    ans.hits   = hit_tally;
    ans.misses = miss_tally;
    return ans;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one transfer on the input channel; prediction taken at the accepting edge
  task automatic send_start(input logic [KEY_BITS-1:0] value);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    start_value_i = value;
    do @(posedge clk_i); while (!in_ready_o);
    expected_answers.push_back(collatz_lookup(value));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    while (expected_answers.size() != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MODE) begin
      evict_random = data[0];
    end else if (idx == REG_SEED) begin
      victim_lfsr = (data == '0) ? LFSR_ONE : data;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly recent values so hits and evictions keep happening
  function automatic logic [KEY_BITS-1:0] pick_start();
    logic [KEY_BITS-1:0] v;
    int                  roll;
    roll = $urandom_range(0, 99);
    if (roll < 55 && recent_starts.size() > 0) begin
      v = recent_starts[$urandom_range(0, recent_starts.size() - 1)];
    end else begin
      if (roll < 90) v = KEY_BITS'($urandom_range(1, 4095));
      else v = KEY_BITS'($urandom());
      recent_starts.push_back(v);
      if (recent_starts.size() > RECENT_DEPTH) void'(recent_starts.pop_front());
    end
    return v;
  endfunction

  task automatic test_first_lookups();
    idling = 1'b0;
    send_start(20'd1);
    send_start(20'd0);
    send_start(20'hFFFFF);
    send_start(20'd2);
    send_start(20'd3);
    send_start(20'd27);
    send_start(20'd837799);
    send_start(20'd27);
    send_start(20'd0);
  endtask

  task automatic test_register_writes();
    write_reg(REG_MODE, 16'hFFFF);
    write_reg(REG_SEED, 16'h0000);
    write_reg(REG_UNUSED_LO, 16'h1234);
    write_reg(REG_UNUSED_HI, 16'hFFFF);
    write_reg(REG_SEED, 16'hFFFF);
    write_reg(REG_MODE, 16'hFFFE);
  endtask

  task automatic test_lru_replacement();
    idling = 1'b1;
    write_reg(REG_MODE, MODE_LRU);
    for (int i = 0; i < 9; i++) send_start(KEY_BITS'(1000 + i));
    send_start(20'd2);
    send_start(20'd1);
  endtask

  task automatic test_random_replacement();
    write_reg(REG_MODE, MODE_RANDOM);
    write_reg(REG_SEED, 16'hACE1);
    for (int i = 0; i < 6; i++) send_start(KEY_BITS'(2000 + 7 * i));
  endtask

  task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] mode,
                                     input logic [CFG_DATA_W-1:0] seed,
                                     input int count, input bit with_idle);
    write_reg(REG_MODE, mode);
    write_reg(REG_SEED, seed);
    idling = with_idle;
    for (int i = 0; i < count; i++) send_start(pick_start());
  endtask

  // result side: random stall bursts on out_ready_i
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (idling && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        report_error($sformatf("unexpected result transfer, step_count %0d", step_count_o));
      end else begin
        exp_ans = expected_answers.pop_front();
        if (step_count_o !== exp_ans.steps)
          report_error($sformatf("step_count got %0d exp %0d", step_count_o, exp_ans.steps));
        if (was_hit_o !== exp_ans.hit)
          report_error($sformatf("was_hit got %0b exp %0b", was_hit_o, exp_ans.hit));
        if (hit_total_o !== exp_ans.hits)
          report_error($sformatf("hit_total got %0d exp %0d", hit_total_o, exp_ans.hits));
        if (miss_total_o !== exp_ans.misses)
          report_error($sformatf("miss_total got %0d exp %0d", miss_total_o, exp_ans.misses));
      end
    end
  end

  // any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    start_value_i  = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    idling         = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    hit_tally      = '0;
    miss_tally     = '0;
    victim_lfsr    = LFSR_ONE;
    evict_random   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      memo_key[i]   = '0;
      memo_steps[i] = '0;
      memo_valid[i] = 1'b0;
      memo_rank[i]  = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_first_lookups();
    test_register_writes();
    test_lru_replacement();
    test_random_replacement();
    test_random_traffic(MODE_LRU, 16'h0001, 300, 1'b1);
    test_random_traffic(MODE_RANDOM, 16'h0001, 300, 1'b1);
    test_random_traffic(MODE_RANDOM, 16'hFFFF, 300, 1'b0);
    test_random_traffic(MODE_RANDOM, 16'($urandom_range(0, 65535)), 300, 1'b1);
    test_random_traffic(MODE_LRU, 16'($urandom_range(0, 65535)), 400, 1'b0);

    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
